/* rtl/lru_key_value_cache_core_macros.svh */
// Assertion macros for the LRU key-value cache.
// Used by the controller and the top level; no other dependencies.
`ifndef LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH

// Implication checked every clock, quiet during reset.
`define LKV_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet during reset.
`define LKV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/lkvc_pkg.sv */
// Shared types and constants for the LRU key-value cache.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lkvc_pkg;
   localparam int ENTRIES_DEFAULT = 16;
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic {
      CMD_GET = 1'b0,
      CMD_PUT = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request word
      logic exec;     // perform lookup and update
      logic clear;    // empty the store
   } ctl_cmd_type;
endpackage
`default_nettype wire

/* rtl/lkvc_ctrl.sv */
// Controller state machine for the LRU key-value cache.
// Depends on lkvc_pkg and the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "lru_key_value_cache_core_macros.svh"
module lkvc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_fire,
   input  wire logic                 rsp_fire,
   input  wire logic                 csr_we,
   output lkvc_pkg::state_type       state,
   output lkvc_pkg::ctl_cmd_type     cmd
);
   lkvc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lkvc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lkvc_pkg::ST_IDLE: if (req_fire) state_in = lkvc_pkg::ST_EXEC;
         lkvc_pkg::ST_EXEC: state_in = lkvc_pkg::ST_RESP;
         lkvc_pkg::ST_RESP: begin
            if (rsp_fire) state_in = lkvc_pkg::ST_IDLE;
         end
         default: state_in = lkvc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         lkvc_pkg::ST_IDLE: cmd.load = req_fire;
         lkvc_pkg::ST_EXEC: cmd.exec = 1'b1;
         default: ;
      endcase
      cmd.clear = csr_we;
   end

   assign state = state_ff;

   `LKV_ASSERT_NEXT(a_exec_follows_load, clock, reset, cmd.load, state_ff == lkvc_pkg::ST_EXEC, "load not followed by exec")
   `LKV_ASSERT_NEXT(a_exec_to_resp, clock, reset, state_ff == lkvc_pkg::ST_EXEC, state_ff == lkvc_pkg::ST_RESP, "exec not followed by resp")
   `LKV_ASSERT_IMPL(a_one_cmd, clock, reset, 1'b1, !(cmd.load && cmd.exec), "load and exec together")
endmodule
`default_nettype wire

/* rtl/lkvc_datapath.sv */
// Datapath: recency-ordered entry store, parallel key compare, result register.
// Depends on lkvc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lkvc_datapath #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  lkvc_pkg::ctl_cmd_type              cmd,
   input  wire logic [lkvc_pkg::CAP_W-1:0]    capacity,
   input  wire logic                          req_command,
   input  wire logic [lkvc_pkg::KEY_W-1:0]    req_key,
   input  wire logic [lkvc_pkg::VAL_W-1:0]    req_value,
   output logic                               hit,
   output logic [lkvc_pkg::VAL_W-1:0]         read_value,
   output logic                               evicted,
   output logic [lkvc_pkg::KEY_W-1:0]         evicted_key
);
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OW = $clog2(ENTRIES + 1);

   // slot 0 most recent; valid slots form a prefix
   logic [lkvc_pkg::KEY_W-1:0] keys_ff [ENTRIES];
   logic [lkvc_pkg::VAL_W-1:0] vals_ff [ENTRIES];
   logic [ENTRIES-1:0]         valid_ff;
   logic [OW-1:0]              occ_ff;

   logic                       cmd_ff;
   logic [lkvc_pkg::KEY_W-1:0] key_ff;
   logic [lkvc_pkg::VAL_W-1:0] val_ff;

   logic                       hit_ff, ev_ff;
   logic [lkvc_pkg::VAL_W-1:0] rd_ff;
   logic [lkvc_pkg::KEY_W-1:0] evk_ff;

   logic [ENTRIES-1:0] match;
   logic [IW-1:0]      pos;
   logic               found;
   logic [OW-1:0]      cap_eff;
   logic               full;
   logic [IW-1:0]      shift_top;   // slots 1..shift_top take their neighbor at the next lower index

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_command;
         key_ff <= req_key;
         val_ff <= req_value;
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) match[i] = valid_ff[i] && (keys_ff[i] == key_ff);
   end

   // lowest matching slot
   always_comb begin
      pos = '0;
      found = 1'b0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            pos = IW'(i);
            found = 1'b1;
         end
      end
   end

   always_comb begin
      if (capacity == '0) cap_eff = OW'(1);
      else if ({27'd0, capacity} > ENTRIES) cap_eff = OW'(ENTRIES);
      else cap_eff = OW'(capacity);
      full = (occ_ff >= cap_eff);
      if (found) shift_top = pos;
      else if (full) shift_top = IW'(occ_ff - OW'(1));
      else shift_top = IW'(occ_ff);   // unused slot when occ == ENTRIES cannot happen here
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         valid_ff <= '0;
         occ_ff   <= '0;
      end else if (cmd.exec && (found || cmd_ff == lkvc_pkg::CMD_PUT)) begin
         for (int i = ENTRIES - 1; i > 0; i--) begin
            if (IW'(i) <= shift_top) begin
               keys_ff[i]  <= keys_ff[i-1];
               vals_ff[i]  <= vals_ff[i-1];
               valid_ff[i] <= valid_ff[i-1];
            end
         end
         keys_ff[0]  <= key_ff;
         vals_ff[0]  <= (cmd_ff == lkvc_pkg::CMD_PUT) ? val_ff : vals_ff[pos];
         valid_ff[0] <= 1'b1;
         if (!found && !full) occ_ff <= occ_ff + OW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         hit_ff <= found;
         rd_ff  <= (found && cmd_ff == lkvc_pkg::CMD_GET) ? vals_ff[pos] : '0;
         ev_ff  <= !found && cmd_ff == lkvc_pkg::CMD_PUT && full;
         evk_ff <= (!found && cmd_ff == lkvc_pkg::CMD_PUT && full)
                   ? keys_ff[IW'(occ_ff - OW'(1))] : '0;
      end
   end

   assign hit         = hit_ff;
   assign read_value  = rd_ff;
   assign evicted     = ev_ff;
   assign evicted_key = evk_ff;
endmodule
`default_nettype wire

/* rtl/lru_key_value_cache_core.sv */
// Top level of the LRU key-value cache: stream ports, capacity register.
// Depends on lkvc_pkg, lkvc_ctrl, lkvc_datapath and the macros header.
// A request word accepted in idle is looked up in the execute state; the registered
//   response word is then valid in the respond state until it is taken. One request in
//   flight, set by the controller's load/execute/respond sequence.
// Reset: synchronous, active high; empties the store, capacity back to 16.
// Writing capacity empties the store in the same edge.
`timescale 1ns / 1ps
`default_nettype none
`include "lru_key_value_cache_core_macros.svh"
module lru_key_value_cache_core #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic        req_tuser,   // command[0]
   input  wire logic [63:0] req_tdata,   // lookup_key[31:0], store_value[63:32]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // hit[0], read_value[32:1], evicted[33], evicted_key[65:34]
   input  wire logic        csr_we,
   input  wire logic [4:0]  csr_wdata    // capacity
);
   logic [lkvc_pkg::CAP_W-1:0] cap_ff;
   lkvc_pkg::state_type        state;
   lkvc_pkg::ctl_cmd_type      cmd;
   logic                       hit, evicted;
   logic [31:0]                read_value, evicted_key;
   logic                       req_fire, rsp_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lkvc_pkg::CAP_RESET;
      end else if (csr_we) begin
         cap_ff <= csr_wdata;
      end
   end

   assign req_tready = (state == lkvc_pkg::ST_IDLE);
   assign rsp_tvalid = (state == lkvc_pkg::ST_RESP);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   lkvc_ctrl u_ctrl (
      .clock, .reset, .req_fire, .rsp_fire, .csr_we, .state, .cmd
   );

   lkvc_datapath #(.ENTRIES(ENTRIES)) u_dp (
      .clock, .reset, .cmd,
      .capacity    (cap_ff),
      .req_command (req_tuser),
      .req_key     (req_tdata[31:0]),
      .req_value   (req_tdata[63:32]),
      .hit, .read_value, .evicted, .evicted_key
   );

   assign rsp_tdata = {6'd0, evicted_key, evicted, read_value, hit};

   `LKV_ASSERT_IMPL(a_no_dual, clock, reset, 1'b1, !(req_tready && rsp_tvalid), "ready while response pending")
   `LKV_ASSERT_IMPL(a_miss_zero, clock, reset, rsp_tvalid && !hit, read_value == '0, "miss with nonzero value")
   `LKV_ASSERT_IMPL(a_evict_miss, clock, reset, rsp_tvalid && evicted, !hit, "eviction on hit")
endmodule
`default_nettype wire
